>>> rtl/crmg_pkg.sv
// shared types and constants of the coupled renyi map generator
`timescale 1ns / 1ps
`default_nettype none
package crmg_pkg;

  localparam int NUM_MAPS  = 4;
  localparam int IDX_W     = $clog2(NUM_MAPS);
  localparam int WORD_W    = 32;
  localparam int PERT_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W = 8;
  // map_value, map_index, round_sum packed, padded to whole bytes
  localparam int OUT_RAW_W  = WORD_W + IDX_W + WORD_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  map_idx_t;
  typedef logic [PERT_W-1:0] pert_t;

  // register indexes: gains first, then seeds
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_BASE = 3'd4;

  localparam map_idx_t LAST_MAP = map_idx_t'(NUM_MAPS - 1);

  localparam word_t GAIN_RESET [NUM_MAPS] = '{32'd131071, 32'd104729, 32'd524287, 32'd65537};
  localparam word_t SEED_RESET [NUM_MAPS] = '{32'd653, 32'd769, 32'd227, 32'd823};

  // control from the sequencer to the shared update unit
  typedef struct packed {
    logic load;     // capture product and shift term of the operand
    logic coupled;  // add the signed perturbation in this update
  } unit_ctl_t;

endpackage
`default_nettype wire

>>> rtl/coupled_renyi_map_generator_unit.sv
// top level: config registers, map state, sequencer and output register
`timescale 1ns / 1ps
`default_nettype none
// sequence: every map update is a multiply step, then an add step, all through
//   the single shared multiplier; a request with priming first updates each map from its seed
// round: one result beat per map update, held while the previous beat has not left;
//   a new request is taken only in idle, after the last beat of the round is registered
// reset: synchronous active low; restores default gains and seeds, clears the
//   perturbation, sign and primed flag; map state is loaded by priming, never reset
module coupled_renyi_map_generator_unit #(
  parameter int SHIFT = 9
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input beat
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [crmg_pkg::IN_DATA_W-1:0]      in_tdata,   // [0] reseed, rest zero
  // result beat
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [crmg_pkg::OUT_DATA_W-1:0]     out_tdata,  // map_value, map_index, round_sum
  output logic                                out_tlast,
  // configuration writes
  input  wire                                 cfg_we,
  input  wire  [crmg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [crmg_pkg::WORD_W-1:0]         cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME_MUL,
    ST_PRIME_ADD,
    ST_RUN_MUL,
    ST_RUN_ADD
  } state_t;

  state_t               state_r;
  crmg_pkg::map_idx_t   idx_r;
  crmg_pkg::word_t      acc_r;
  crmg_pkg::pert_t      pert_r;
  logic                 sign_neg_r;
  logic                 primed_r;
  crmg_pkg::word_t      gain_r  [crmg_pkg::NUM_MAPS];
  crmg_pkg::word_t      seed_r  [crmg_pkg::NUM_MAPS];
  crmg_pkg::word_t      map_r   [crmg_pkg::NUM_MAPS];

  logic                 out_valid_r;
  crmg_pkg::word_t      out_value_r;
  crmg_pkg::map_idx_t   out_index_r;
  crmg_pkg::word_t      out_sum_r;
  logic                 out_last_r;

  crmg_pkg::unit_ctl_t  ctl;
  crmg_pkg::word_t      unit_x;
  crmg_pkg::word_t      unit_res;
  crmg_pkg::word_t      acc_sum;
  logic                 out_free;
  logic                 map_we;
  logic                 in_beat;
  logic                 is_last_map;

  assign in_tready   = (state_r == ST_IDLE);
  assign in_beat     = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign is_last_map = (idx_r == crmg_pkg::LAST_MAP);
  assign acc_sum     = acc_r + unit_res;

  // operand select: seeds while priming, current map state otherwise
  assign unit_x      = (state_r == ST_PRIME_MUL) ? seed_r[idx_r] : map_r[idx_r];
  assign ctl.load    = (state_r == ST_PRIME_MUL) || (state_r == ST_RUN_MUL);
  assign ctl.coupled = (state_r == ST_RUN_MUL);

  // map state is written on every completed update
  assign map_we = (state_r == ST_PRIME_ADD) || ((state_r == ST_RUN_ADD) && out_free);

  crmg_unit #(
    .SHIFT(SHIFT)
  ) u_unit (
    .clk      (clk),
    .ctl      (ctl),
    .x        (unit_x),
    .gain     (gain_r[idx_r]),
    .pert     (pert_r),
    .sign_neg (sign_neg_r),
    .result   (unit_res)
  );

  // map state store, no reset
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_r[idx_r] <= unit_res;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < crmg_pkg::NUM_MAPS; i++) begin
        gain_r[i] <= crmg_pkg::GAIN_RESET[i];
        seed_r[i] <= crmg_pkg::SEED_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index < crmg_pkg::CFG_SEED_BASE) begin
        gain_r[crmg_pkg::map_idx_t'(cfg_index - crmg_pkg::CFG_GAIN_BASE)] <= cfg_wdata;
      end else begin
        seed_r[crmg_pkg::map_idx_t'(cfg_index - crmg_pkg::CFG_SEED_BASE)] <= cfg_wdata;
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      acc_r       <= '0;
      pert_r      <= '0;
      sign_neg_r  <= 1'b0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_value_r <= '0;
      out_index_r <= '0;
      out_sum_r   <= '0;
      out_last_r  <= 1'b0;
    end else begin
      // in run-add a leaving beat is replaced by the next one below
      if (out_valid_r && out_tready && (state_r != ST_RUN_ADD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            idx_r <= '0;
            acc_r <= '0;
            // an unprimed generator always primes first
            if (in_tdata[0] || !primed_r) begin
              state_r <= ST_PRIME_MUL;
            end else begin
              state_r <= ST_RUN_MUL;
            end
          end
        end
        ST_PRIME_MUL: begin
          state_r <= ST_PRIME_ADD;
        end
        ST_PRIME_ADD: begin
          if (is_last_map) begin
            // warm-up sum seeds the perturbation, sign back to plus
            pert_r     <= acc_sum[crmg_pkg::PERT_W-1:0];
            sign_neg_r <= 1'b0;
            primed_r   <= 1'b1;
            acc_r      <= '0;
            idx_r      <= '0;
            state_r    <= ST_RUN_MUL;
          end else begin
            acc_r   <= acc_sum;
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_PRIME_MUL;
          end
        end
        ST_RUN_MUL: begin
          state_r <= ST_RUN_ADD;
        end
        ST_RUN_ADD: begin
          // hold here until the previous beat has left
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= unit_res;
            out_index_r <= idx_r;
            out_last_r  <= is_last_map;
            out_sum_r   <= is_last_map ? acc_sum : '0;
            if (is_last_map) begin
              // coupling for the next round: odd low byte keeps plus
              pert_r     <= acc_sum[crmg_pkg::PERT_W-1:0];
              sign_neg_r <= !acc_sum[0];
              acc_r      <= '0;
              idx_r      <= '0;
              state_r    <= ST_IDLE;
            end else begin
              acc_r   <= acc_sum;
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_RUN_MUL;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(crmg_pkg::OUT_DATA_W - crmg_pkg::OUT_RAW_W){1'b0}},
                       out_sum_r, out_index_r, out_value_r};

endmodule
`default_nettype wire

>>> rtl/crmg_unit.sv
// shared renyi update unit: registered product, then add of shift term and perturbation
`timescale 1ns / 1ps
`default_nettype none
module crmg_unit #(
  parameter int SHIFT = 9
) (
  input  wire                     clk,
  input  wire crmg_pkg::unit_ctl_t ctl,
  input  wire crmg_pkg::word_t    x,
  input  wire crmg_pkg::word_t    gain,
  input  wire crmg_pkg::pert_t    pert,
  input  wire                     sign_neg,
  output crmg_pkg::word_t         result
);

  crmg_pkg::word_t prod_r;
  crmg_pkg::word_t shr_r;
  logic            coupled_r;
  crmg_pkg::word_t pert_ext;
  crmg_pkg::word_t addend;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r    <= x * gain;
      shr_r     <= x >> SHIFT;
      coupled_r <= ctl.coupled;
    end
  end

  assign pert_ext = {{(crmg_pkg::WORD_W - crmg_pkg::PERT_W){1'b0}}, pert};

  always_comb begin
    if (!coupled_r) begin
      addend = '0;
    end else if (sign_neg) begin
      addend = crmg_pkg::word_t'(0) - pert_ext;
    end else begin
      addend = pert_ext;
    end
  end

  assign result = prod_r + shr_r + addend;

endmodule
`default_nettype wire

>>> rtl/crmg_checker.sv
// port-level checker for the generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module crmg_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_tvalid,
  input wire                                in_tready,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [crmg_pkg::OUT_DATA_W-1:0]     out_tdata,
  input wire                                out_tlast
);

  // a waiting beat is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // ready drops after an accepted request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // round sum shows only on the last beat
  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[65:34] == 32'd0)
    else $error("round sum on a non-last beat");

  // last beat comes from the last map
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[33:32] == crmg_pkg::LAST_MAP)
    else $error("last beat from wrong map");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind coupled_renyi_map_generator_unit crmg_checker u_crmg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
